// ----- rtl/rmth_pkg.sv -----
// Shared types and constants for the running median unit.
`default_nettype none
package rmth_pkg;

   // Operation the heap sequencer runs on one heap.
   typedef enum logic [1:0] {
      HOP_INSERT  = 2'd0,
      HOP_PUSHPOP = 2'd1
   } heap_op_type;

   localparam int MEDIAN_BITS = 32;
   localparam int COUNT_BITS  = 11;

endpackage
`default_nettype wire

// ----- rtl/running_median_two_heaps_unit.sv -----
// Top level: running median over two heaps with a step sequencer.
// channel | direction | words
// req_    | in        | sample, restart
// rsp_    | out       | median, count, dropped
// Push-pop sifts down by read-left, read-right, compare-left and compare steps per level,
// insert sifts up by read and compare steps per level, over log2(CAPACITY/2) levels;
// a sample runs at most one push-pop then one insert.
// Reset is synchronous; both heaps come up empty. req_ready is low while a sample
// is in work or its result waits; a stalled rsp_ holds the word.
`default_nettype none
module running_median_two_heaps_unit #(
   parameter int CAPACITY = 1024,
   parameter int SAMPLE_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [rmth_pkg::MEDIAN_BITS-1:0] req_sample,
   input  wire logic                                   req_restart,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [rmth_pkg::MEDIAN_BITS-1:0]     rsp_median,
   output logic [rmth_pkg::COUNT_BITS-1:0]             rsp_count,
   output logic                                        rsp_dropped
);
   import rmth_pkg::*;

   localparam int DEPTH = (CAPACITY + 1) / 2;
   localparam int HSW = $clog2(DEPTH + 1);
   localparam int TW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {S_IDLE, S_FIRST, S_SECOND, S_OUT} state_type;

   state_type               state_ff;
   logic                    lo_start, up_start, lo_done, up_done, lo_clear, up_clear;
   heap_op_type             lo_op, up_op;
   logic [SAMPLE_BITS-1:0]  lo_key, up_key, lo_res, up_res, lo_top, up_top;
   logic [HSW-1:0]          lo_size, up_size;
   logic                    second_lo_ff;   // second sift goes to lower heap
   logic                    two_ff;
   logic                    dropped_ff;
   logic [TW-1:0]           total;
   logic [SAMPLE_BITS-1:0]  raw_sample, lo_value;
   logic [SAMPLE_BITS-1:0]  in_key, mid_key;

   // low SAMPLE_BITS of the word; flip sign bit so unsigned compare gives signed order
   assign raw_sample = SAMPLE_BITS'({{SAMPLE_BITS{1'b0}}, req_sample});
   assign in_key = {~raw_sample[SAMPLE_BITS-1], raw_sample[SAMPLE_BITS-2:0]};
   assign lo_value = {~lo_top[SAMPLE_BITS-1], lo_top[SAMPLE_BITS-2:0]};
   assign total  = TW'(lo_size) + TW'(up_size);

   rmth_heap #(.DEPTH(DEPTH), .KEY_BITS(SAMPLE_BITS), .IS_MAX(1'b1)) u_lower (
      .clock, .reset, .clear(lo_clear), .start(lo_start), .op(lo_op), .key(lo_key),
      .done(lo_done), .result(lo_res), .top(lo_top), .size(lo_size));
   rmth_heap #(.DEPTH(DEPTH), .KEY_BITS(SAMPLE_BITS), .IS_MAX(1'b0)) u_upper (
      .clock, .reset, .clear(up_clear), .start(up_start), .op(up_op), .key(up_key),
      .done(up_done), .result(up_res), .top(up_top), .size(up_size));

   logic acc;
   logic restart_eff;
   logic lo_empty, goes_up, lo_bigger;
   assign acc       = req_valid && req_ready;
   assign restart_eff = acc && req_restart;
   assign lo_clear  = restart_eff;
   assign up_clear  = restart_eff;
   assign lo_empty  = req_restart || lo_size == '0;
   assign goes_up   = in_key >= lo_top;
   assign lo_bigger = lo_size > up_size;
   assign mid_key   = second_lo_ff ? up_res : lo_res;

   always_comb begin
      lo_start = 1'b0; up_start = 1'b0;
      lo_op = HOP_INSERT; up_op = HOP_INSERT;
      lo_key = in_key; up_key = in_key;
      if (state_ff == S_IDLE && acc && !(!req_restart && total >= TW'(CAPACITY))) begin
         if (lo_empty) lo_start = 1'b1;
         else if (goes_up) begin
            up_start = 1'b1;
            up_op = lo_bigger ? HOP_INSERT : HOP_PUSHPOP;
         end else begin
            lo_start = 1'b1;
            lo_op = lo_bigger ? HOP_PUSHPOP : HOP_INSERT;
         end
      end
      if (state_ff == S_FIRST && two_ff && (lo_done || up_done)) begin
         if (second_lo_ff) begin lo_start = 1'b1; lo_key = mid_key; end
         else begin up_start = 1'b1; up_key = mid_key; end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (acc) begin
               dropped_ff <= !req_restart && total >= TW'(CAPACITY);
               if (!req_restart && total >= TW'(CAPACITY)) state_ff <= S_OUT;
               else begin
                  state_ff <= S_FIRST;
                  two_ff <= !lo_empty && (goes_up ? !lo_bigger : lo_bigger);
                  second_lo_ff <= goes_up;
               end
            end
            S_FIRST: if (lo_done || up_done) state_ff <= two_ff ? S_SECOND : S_OUT;
            S_SECOND: if (lo_done || up_done) state_ff <= S_OUT;
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = state_ff == S_OUT;
   assign rsp_median  = (lo_size == '0) ? '0
                                        : MEDIAN_BITS'({{MEDIAN_BITS{1'b0}}, lo_value});
   assign rsp_count   = COUNT_BITS'(total);
   assign rsp_dropped = dropped_ff;

`ifndef SYNTHESIS
   a_size_balance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (lo_size == up_size || lo_size == up_size + 1'b1))
      else $error("heap sizes out of balance");
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> total <= TW'(CAPACITY))
      else $error("count above capacity");
   a_one_heap_busy: assert property (@(posedge clock) disable iff (reset)
      !(lo_start && up_start))
      else $error("both heaps started");
`endif
endmodule
`default_nettype wire

// ----- rtl/rmth_heap.sv -----
// One binary heap in a memory, with a sift sequencer for insert and push-pop.
`default_nettype none
module rmth_heap #(
   parameter int DEPTH = 512,
   parameter int KEY_BITS = 32,
   parameter bit IS_MAX = 1'b1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clear,
   input  wire logic                     start,
   input  wire rmth_pkg::heap_op_type    op,
   input  wire logic [KEY_BITS-1:0]      key,
   output logic                          done,
   output logic [KEY_BITS-1:0]           result,
   output logic [KEY_BITS-1:0]           top,
   output logic [$clog2(DEPTH+1)-1:0]    size
);
   import rmth_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = $clog2(DEPTH+1);

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMPL, S_DN_CMP, S_WR_CHILD
   } state_type;

   logic [KEY_BITS-1:0] mem [DEPTH];
   logic [KEY_BITS-1:0] rd_data_ff;
   logic [KEY_BITS-1:0] top_ff, top_in;
   logic [KEY_BITS-1:0] cur_ff, cur_in;     // key being sifted
   logic [KEY_BITS-1:0] best_ff, best_in;   // best child value
   logic [KEY_BITS-1:0] result_ff, result_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [SW:0]         idx_ff, idx_in;     // current hole position
   logic [SW:0]         bidx_ff, bidx_in;
   state_type           state_ff, state_in;
   logic                done_ff, done_in;

   logic                we;
   logic [AW-1:0]       waddr, raddr;
   logic [KEY_BITS-1:0] wdata;
   logic [SW:0]         parent, lchild, rchild;
   logic [SW-1:0]       base_size;          // size seen by a new op, empty on clear

   function automatic logic above(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
      above = IS_MAX ? (a > b) : (a < b);
   endfunction

   assign parent    = (idx_ff - 1'b1) >> 1;
   assign lchild    = {idx_ff[SW-1:0], 1'b1};
   assign rchild    = lchild + 1'b1;
   assign base_size = clear ? '0 : size_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      bidx_in   = bidx_ff;
      cur_in    = cur_ff;
      best_in   = best_ff;
      result_in = result_ff;
      size_in   = base_size;
      top_in    = top_ff;
      done_in   = 1'b0;
      we        = 1'b0;
      waddr     = idx_ff[AW-1:0];
      wdata     = cur_ff;
      raddr     = parent[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cur_in = key;
               if (op == HOP_INSERT) begin
                  result_in = key;
                  idx_in    = {1'b0, base_size};
                  size_in   = base_size + 1'b1;
                  if (base_size == '0) begin
                     we = 1'b1; waddr = '0; wdata = key;
                     top_in = key; done_in = 1'b1;
                  end else begin
                     state_in = S_UP_RD;
                  end
               end else if (base_size == '0 || !above(top_ff, key)) begin
                  result_in = key;
                  done_in   = 1'b1;
               end else begin
                  result_in = top_ff;
                  top_in    = key;
                  idx_in    = '0;
                  state_in  = S_DN_RDL;
               end
            end
         end
         S_UP_RD: state_in = S_UP_CMP;   // parent read issued here
         S_UP_CMP: begin
            if (above(cur_ff, rd_data_ff)) begin
               we = 1'b1; wdata = rd_data_ff;   // parent moves down into the hole
               idx_in = parent;
               if (parent == '0) begin
                  we = 1'b1;
                  state_in = S_WR_CHILD;
               end else begin
                  state_in = S_UP_RD;
               end
            end else begin
               we = 1'b1;
               if (idx_ff == '0) top_in = cur_ff;
               done_in = 1'b1; state_in = S_IDLE;
            end
         end
         S_WR_CHILD: begin
            we = 1'b1;
            if (idx_ff == '0) top_in = cur_ff;
            done_in = 1'b1; state_in = S_IDLE;
         end
         S_DN_RDL: begin
            raddr = lchild[AW-1:0];
            if (lchild >= {1'b0, size_ff}) begin
               we = 1'b1;
               done_in = 1'b1; state_in = S_IDLE;
            end else begin
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            raddr = rchild[AW-1:0];
            best_in = rd_data_ff; bidx_in = lchild;
            state_in = (rchild < {1'b0, size_ff}) ? S_DN_CMPL : S_DN_CMP;
         end
         S_DN_CMPL: begin
            if (above(rd_data_ff, best_ff)) begin
               best_in = rd_data_ff; bidx_in = rchild;
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (above(best_ff, cur_ff)) begin
               we = 1'b1; wdata = best_ff;
               if (idx_ff == '0) top_in = best_ff;
               idx_in = bidx_ff;
               state_in = S_DN_RDL;
            end else begin
               we = 1'b1;
               done_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_data_ff <= mem[raddr];
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      bidx_ff   <= bidx_in;
      result_ff <= result_in;
      top_ff    <= top_in;
      idx_ff    <= idx_in;
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         done_ff  <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
   assign top    = top_ff;
   assign size   = size_ff;
endmodule
`default_nettype wire
